>>> rtl/cbp_pkg.sv
// shared types, constants and functions of the color bar pattern generator
`timescale 1ns / 1ps

package cbp_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;   // holds MAX_DIM itself
  localparam int POS_W      = 12;   // pixel coordinate
  localparam int BAR_BITS   = 3;    // bar index, wraps modulo 8
  localparam int OFFSET_W   = 26;
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSETS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTHS  = 3'd5;

  localparam logic [23:0] WHITE = 24'hFFFFFF;

  localparam logic [23:0] BAR_COLORS [8] = '{
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h000000
  };

  typedef struct packed {
    logic [12:0] width_pixels;
    logic [12:0] height_pixels;
    logic [14:0] stride_bytes;
    logic        depth_mode;
    logic [14:0] channel_offsets;
    logic [11:0] channel_lengths;
  } cfg_t;

  typedef struct packed {
    logic load;      // take the input word, set up coordinates
    logic div_step;  // one quotient bit of the bar index
    logic store;     // write the result into the output register
  } cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pack_channel(logic [7:0] v, logic [3:0] len,
                                                     logic [4:0] off);
    logic [3:0] l;
    logic [7:0] t;
    l = (len > 4'd8) ? 4'd8 : len;
    t = v >> (4'd8 - l);
    return {24'd0, t} << off;
  endfunction

  function automatic logic [WORD_W-1:0] pack_color(logic [23:0] rgb, logic [11:0] lens,
                                                   logic [14:0] offs);
    return pack_channel(rgb[23:16], lens[11:8], offs[14:10])
         | pack_channel(rgb[15:8],  lens[7:4],  offs[9:5])
         | pack_channel(rgb[7:0],   lens[3:0],  offs[4:0]);
  endfunction

endpackage

>>> rtl/cbp_cfg_regs.sv
// configuration register bank
`timescale 1ns / 1ps

module cbp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0] wr_data,
  output cbp_pkg::cfg_t                cfg
);
  import cbp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_pixels    <= 13'd640;
      cfg_r.height_pixels   <= 13'd480;
      cfg_r.stride_bytes    <= 15'd2560;
      cfg_r.depth_mode      <= 1'b1;
      cfg_r.channel_offsets <= 15'd16392;
      cfg_r.channel_lengths <= 12'd2184;
    end else if (wr_en) begin
      case (wr_index)
        REG_WIDTH:   cfg_r.width_pixels    <= wr_data[12:0];
        REG_HEIGHT:  cfg_r.height_pixels   <= wr_data[12:0];
        REG_STRIDE:  cfg_r.stride_bytes    <= wr_data[14:0];
        REG_DEPTH:   cfg_r.depth_mode      <= wr_data[0];
        REG_OFFSETS: cfg_r.channel_offsets <= wr_data[14:0];
        REG_LENGTHS: cfg_r.channel_lengths <= wr_data[11:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/cbp_ctrl.sv
// sequencing controller: load, bar index steps, output register handoff
`timescale 1ns / 1ps

module cbp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output cbp_pkg::cmd_t cmd
);
  import cbp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam int STEP_W = $clog2(BAR_BITS);

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(BAR_BITS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.store     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/cbp_datapath.sv
// raster counters, bar index divider, offset and pixel packing, output register
`timescale 1ns / 1ps

module cbp_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cbp_pkg::cmd_t               cmd,
  input  cbp_pkg::cfg_t               cfg,
  input  logic                        restart_frame,
  output logic [cbp_pkg::POS_W-1:0]    pixel_x,
  output logic [cbp_pkg::POS_W-1:0]    pixel_y,
  output logic [cbp_pkg::OFFSET_W-1:0] byte_offset,
  output logic [cbp_pkg::WORD_W-1:0]   pixel_word,
  output logic                        wide_write,
  output logic                        frame_last
);
  import cbp_pkg::*;

  localparam int REM_W = DIM_W + 1;

  logic [DIM_W-1:0]    w, h;
  logic [POS_W-1:0]    col_r, row_r, col_nxt, row_nxt;
  logic [POS_W-1:0]    xs, ys;
  logic [DIM_W-1:0]    x1, y1;
  logic                edge_c, last_c;
  logic [OFFSET_W-1:0] offs_c;

  logic [POS_W-1:0]    x_r, y_r;
  logic                edge_r, last_r;
  logic [OFFSET_W-1:0] offs_r;
  logic [REM_W-1:0]    rem_r, rem2;
  logic [BAR_BITS-1:0] quo_r;
  logic [23:0]         rgb;
  logic [WORD_W-1:0]   word_c;

  logic [POS_W-1:0]    ox_r, oy_r;
  logic [OFFSET_W-1:0] ooffs_r;
  logic [WORD_W-1:0]   oword_r;
  logic                owide_r, olast_r;

  assign w = clamp_dim(cfg.width_pixels);
  assign h = clamp_dim(cfg.height_pixels);

  // counters past a shrunk frame, or on a frame restart, fold back to zero
  assign xs = (restart_frame || ({1'b0, col_r} >= w)) ? '0 : col_r;
  assign ys = (restart_frame || ({1'b0, row_r} >= h)) ? '0 : row_r;
  assign x1 = {1'b0, xs} + DIM_W'(1);
  assign y1 = {1'b0, ys} + DIM_W'(1);

  assign edge_c = (xs == '0) || (ys == '0) || (x1 == w) || (y1 == h);
  assign last_c = (x1 == w) && (y1 == h);

  assign offs_c = OFFSET_W'(ys) * OFFSET_W'(cfg.stride_bytes)
                + (cfg.depth_mode ? OFFSET_W'({xs, 2'b00}) : OFFSET_W'({xs, 1'b0}));

  always_comb begin
    col_nxt = x1[POS_W-1:0];
    row_nxt = ys;
    if (x1 >= w) begin
      col_nxt = '0;
      row_nxt = (y1 >= h) ? '0 : y1[POS_W-1:0];
    end
  end

  assign rem2 = {rem_r[REM_W-2:0], 1'b0};

  assign rgb    = edge_r ? WHITE : BAR_COLORS[quo_r];
  assign word_c = pack_color(rgb, cfg.channel_lengths, cfg.channel_offsets);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.load) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= xs;
      y_r    <= ys;
      edge_r <= edge_c;
      last_r <= last_c;
      offs_r <= offs_c;
      rem_r  <= {{(REM_W - POS_W){1'b0}}, xs};
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      // restoring step of floor(x * 8 / w), x < w
      if (rem2 >= {1'b0, w}) begin
        rem_r <= rem2 - {1'b0, w};
        quo_r <= {quo_r[BAR_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem2;
        quo_r <= {quo_r[BAR_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ox_r    <= x_r;
      oy_r    <= y_r;
      ooffs_r <= offs_r;
      oword_r <= cfg.depth_mode ? word_c : {16'd0, word_c[15:0]};
      owide_r <= cfg.depth_mode;
      olast_r <= last_r;
    end
  end

  assign pixel_x     = ox_r;
  assign pixel_y     = oy_r;
  assign byte_offset = ooffs_r;
  assign pixel_word  = oword_r;
  assign wide_write  = owide_r;
  assign frame_last  = olast_r;

endmodule

>>> rtl/color_bar_pattern_generator_core.sv
// top level of the color bar test pattern generator
`timescale 1ns / 1ps
//
// raster test pattern source: every input word asks for one pixel
// in_restart_frame = 0 gives the next pixel, 1 restarts the frame at (0,0)
// each output word carries x, y, byte offset (y*stride + x*2 or x*4),
// the packed pixel, the store width and a last-of-frame mark
// the outer one-pixel border is white, inside are eight vertical bars
// input: in_valid / in_stall, accepted when valid is high and stall is low
// output: out_valid / out_stall, the word is held while out_stall is high
// config: cfg_valid / cfg_ready (always ready), cfg_index selects the register;
//   write only while no pixel is in flight
// an accepted word passes the load step, the 3-step bar index divider
//   (floor(x*8/width), one quotient bit a cycle) and the store into the
//   output register, which raises out_valid; the next input word is taken only after that store
// an output word waiting on out_stall does not block the next input word,
//   which then waits in its final step until the output register frees
// reset (rst_n low, synchronous): counters go to (0,0), registers to defaults,
//   output valid drops
//
module color_bar_pattern_generator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_restart_frame,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cbp_pkg::POS_W-1:0]    out_pixel_x,
  output logic [cbp_pkg::POS_W-1:0]    out_pixel_y,
  output logic [cbp_pkg::OFFSET_W-1:0] out_byte_offset,
  output logic [cbp_pkg::WORD_W-1:0]   out_pixel_word,
  output logic                         out_wide_write,
  output logic                         out_frame_last,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbp_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // register bank never pushes back
  assign cfg_ready = 1'b1;

  cbp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // sequencer: idle, divider steps, handoff to the output register
  cbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // counters, divider, offset multiply and color packing
  cbp_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg           (cfg),
    .restart_frame (in_restart_frame),
    .pixel_x       (out_pixel_x),
    .pixel_y       (out_pixel_y),
    .byte_offset   (out_byte_offset),
    .pixel_word    (out_pixel_word),
    .wide_write    (out_wide_write),
    .frame_last    (out_frame_last)
  );

endmodule

>>> bench/tb_color_bar_pattern_generator_core.sv
// self-checking testbench for the color bar pattern generator core
`timescale 1ns / 1ps

module tb_color_bar_pattern_generator_core;
  import cbp_pkg::*;

  localparam int FRAME_MAX = 4096;  // largest usable width or height
  localparam int LATENCY = 4;  // margin added when draining the pipe
  localparam int QUIET_LIMIT = 1000;  // cycles without any handshake before giving up

  // indexes past the last register, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // one expected output word
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0] word;
    logic wide;
    logic last;
  } pixel_t;

  logic clk;
  logic rst_n = 1'b0;

  // every input starts at a known value
  logic in_valid = 1'b0;
  logic in_restart_frame = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic [POS_W-1:0] out_pixel_x;
  logic [POS_W-1:0] out_pixel_y;
  logic [OFFSET_W-1:0] out_byte_offset;
  logic [WORD_W-1:0] out_pixel_word;
  logic out_wide_write;
  logic out_frame_last;
  logic cfg_ready;

  // pixels accepted on the input and not yet seen on the output, oldest first
  pixel_t pending_pixels[$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;  // chance in percent that either side idles or stalls
  int stall_left = 0;

  // register copies, as the block should hold them
  logic [12:0] reg_width;
  logic [12:0] reg_height;
  logic [14:0] reg_stride;
  logic reg_depth;
  logic [14:0] reg_offsets;
  logic [11:0] reg_lengths;

  // raster position of the next pixel
  int unsigned next_col;
  int unsigned next_row;

  color_bar_pattern_generator_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_restart_frame(in_restart_frame),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_byte_offset(out_byte_offset),
    .out_pixel_word(out_pixel_word),
    .out_wide_write(out_wide_write),
    .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // pixel prediction
  // ---------------------------------------------------------------------------

  // width or height as the block uses it: zero acts as one, big values cap
  function automatic int unsigned usable_dim(input logic [12:0] v);
    if (v == 13'd0) begin
      return 1;
    end
    if (v > FRAME_MAX) begin
      return FRAME_MAX;
    end
    return v;
  endfunction

  // bar order left to right: red, green, blue, white, yellow, cyan, magenta, black
  function automatic logic [23:0] bar_rgb(input int unsigned bar);
    case (bar)
      0: return 24'hFF0000;
      1: return 24'h00FF00;
      2: return 24'h0000FF;
      3: return 24'hFFFFFF;
      4: return 24'hFFFF00;
      5: return 24'h00FFFF;
      6: return 24'hFF00FF;
      default: return 24'h000000;
    endcase
  endfunction

  // keep the top len bits of each channel, shift to its offset, drop bits past 31
  function automatic logic [31:0] pack_rgb(input logic [23:0] rgb);
    longint unsigned acc;
    int unsigned chan;
    int unsigned len;
    int unsigned sh;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      chan = rgb[16 - 8 * c +: 8];
      len = reg_lengths[8 - 4 * c +: 4];
      sh = reg_offsets[10 - 5 * c +: 5];
      if (len > 8) begin
        len = 8;
      end
      acc |= longint'(chan >> (8 - len)) << sh;
    end
    return acc[31:0];
  endfunction

  // next output word for one input word, advances the raster position
  function automatic pixel_t predict_pixel(input logic restart);
    pixel_t p;
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    logic [23:0] rgb;
    logic [31:0] word;
    longint unsigned off;
    w = usable_dim(reg_width);
    h = usable_dim(reg_height);
    if (restart) begin
      next_col = 0;
      next_row = 0;
    end
    // position left past the edge by a shrunk frame starts over
    if (next_col >= w) begin
      next_col = 0;
    end
    if (next_row >= h) begin
      next_row = 0;
    end
    x = next_col;
    y = next_row;
    if (x == 0 || y == 0 || x == w - 1 || y == h - 1) begin
      rgb = 24'hFFFFFF;
    end else begin
      rgb = bar_rgb(((x * 8) / w) % 8);
    end
    word = pack_rgb(rgb);
    if (!reg_depth) begin
      word[31:16] = '0;
    end
    off = longint'(y) * longint'(reg_stride) + longint'(x) * (reg_depth ? 4 : 2);
    p.x = x[POS_W-1:0];
    p.y = y[POS_W-1:0];
    p.offset = off[OFFSET_W-1:0];
    p.word = word;
    p.wide = reg_depth;
    p.last = (x == w - 1) && (y == h - 1);
    next_col = x + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = y + 1;
      if (next_row >= h) begin
        next_row = 0;
      end
    end
    return p;
  endfunction

  function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WIDTH: reg_width = data[12:0];
      REG_HEIGHT: reg_height = data[12:0];
      REG_STRIDE: reg_stride = data;
      REG_DEPTH: reg_depth = data[0];
      REG_OFFSETS: reg_offsets = data;
      REG_LENGTHS: reg_lengths = data[11:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // idling on both sides
  // ---------------------------------------------------------------------------

  // mostly a short idle, now and then a long pause
  function automatic int idle_len();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(40, 20);
    end
    return $urandom_range(3, 1);
  endfunction

  // receiver stall, held for a random number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < idle_pct) begin
      out_stall <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // every accepted output word is matched against the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("output word with nothing expected: x %0d y %0d", out_pixel_x, out_pixel_y);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.x, out_pixel_x);
        check_field("pixel_y", want.y, out_pixel_y);
        check_field("byte_offset", want.offset, out_byte_offset);
        check_field("pixel_word", want.word, out_pixel_word);
        check_field("wide_write", want.wide, out_wide_write);
        check_field("frame_last", want.last, out_frame_last);
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
               quiet_cycles, pending_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------

  // one input word; valid stays high on return so back-to-back words need no gap
  task automatic send_pixel(input logic restart);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart_frame <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(predict_pixel(restart));
  endtask

  // stop sending, let every expected word come out, then let the pipe settle
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // cfg_valid is left high so that writes can follow one another
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    store_setting(idx, value[CFG_DATA_W-1:0]);
  endtask

  // full register set, only ever written with the block idle
  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned stride, input int unsigned depth,
                           input int unsigned offs, input int unsigned lens);
    drain_pixels();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_STRIDE, stride);
    write_reg(REG_DEPTH, depth);
    write_reg(REG_OFFSETS, offs);
    write_reg(REG_LENGTHS, lens);
    // now and then poke an unused index, it must leave everything alone
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: 640x480, 32-bit pixels, first pixels and a restart
  task automatic test_default_frame();
    idle_pct = 0;
    send_pixel(1'b0);
    send_pixel(1'b0);
    send_pixel(1'b1);
  endtask

  // 3x3 frame: one bar pixel in the middle, frame end and wrap to the origin
  // all channel lengths over 8 and all offsets at 31, so bits fall off the top
  task automatic test_tiny_frame();
    idle_pct = 30;
    configure(3, 3, 12, 1, 15'h7FFF, 12'hFFF);
    send_pixel(1'b1);
    repeat (9) send_pixel(1'b0);
  endtask

  // zero width acts as one (column left past the edge restarts),
  // zero-length channels, 16-bit store, zero stride
  // then oversize width, zero height with the row left past the edge
  task automatic test_degenerate_sizes();
    idle_pct = 15;
    configure(0, FRAME_MAX, 0, 0, 0, 0);
    send_pixel(1'b0);
    send_pixel(1'b0);
    configure(13'h1FFF, 0, 15'h7FFF, 1, 16392, 2184);
    send_pixel(1'b0);
    send_pixel(1'b1);
  endtask

  // one pixel per line down a tall strip at the widest stride,
  // so the row term of the offset grows large
  task automatic test_tall_strip();
    configure(1, 13'h1FFF, 15'h7FFF, $urandom_range(1), $urandom_range(32767),
              $urandom_range(4095));
    idle_pct = 0;
    send_pixel(1'b1);
    repeat (299) send_pixel(1'b0);
    idle_pct = 15;
    repeat (250) send_pixel(1'b0);
  endtask

  // mostly small frames, some oversize, random layout; plain stepping with a few restarts
  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned offs;
    int unsigned lens;
    repeat (12) begin
      case ($urandom_range(7))
        0: w = 0;
        1: w = $urandom_range(8191, FRAME_MAX);
        default: w = $urandom_range(40, 1);
      endcase
      h = ($urandom_range(7) == 0) ? $urandom_range(8191, 0) : $urandom_range(6, 0);
      offs = ($urandom_range(4) == 0) ? 16392 : $urandom_range(32767);
      lens = ($urandom_range(4) == 0) ? 12'h888 : $urandom_range(4095);
      configure(w, h, $urandom_range(32767), $urandom_range(1), offs, lens);
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      repeat (75) send_pixel($urandom_range(99) < 3);
    end
  endtask

  initial begin
    // power-on register values and raster position
    reg_width = 13'd640;
    reg_height = 13'd480;
    reg_stride = 15'd2560;
    reg_depth = 1'b1;
    reg_offsets = 15'd16392;
    reg_lengths = 12'd2184;
    next_col = 0;
    next_row = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_default_frame();
    test_tiny_frame();
    test_degenerate_sizes();
    test_tall_strip();
    test_random_frames();

    idle_pct = 0;
    drain_pixels();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
